// File: rtl/dqp_pkg.sv
// ----------------------------------------------------------------------------
// dqp_pkg
// Shared types and constants for the dotted-quad list parser.
// ----------------------------------------------------------------------------
package dqp_pkg;

    // Width of the saturating count of valid tokens.
    localparam int COUNT_BITS = 16;
    localparam int INDEX_BITS = 16;

    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    localparam logic [11:0] OCTET_MAX = 12'd255;
    localparam logic [1:0]  LAST_PART = 2'd3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        ST_PARSED    = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_END       = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0]            octet_a;
        logic [7:0]            octet_b;
        logic [7:0]            octet_c;
        logic [7:0]            octet_d;
        status_t               status;
        logic [INDEX_BITS-1:0] token_index;
        logic                  last;
    } result_t;

endpackage

// File: rtl/dqp_parse_core.sv
// ----------------------------------------------------------------------------
// dqp_parse_core
// Token state and the update logic for one text byte.
// ----------------------------------------------------------------------------
module dqp_parse_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  logic [7:0]      char_code,
    input  logic            end_of_input,
    output logic [1:0]      push_count,
    output dqp_pkg::result_t res_first,
    output dqp_pkg::result_t res_second
);
    import dqp_pkg::*;

    logic                  in_token_reg, in_token_next;
    logic [1:0]            part_index_reg, part_index_next;
    logic [7:0]            part_value_reg, part_value_next;
    logic                  has_digit_reg, has_digit_next;
    logic [7:0]            held_a_reg, held_a_next;
    logic [7:0]            held_b_reg, held_b_next;
    logic [7:0]            held_c_reg, held_c_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  halted_reg, halted_next;

    logic                  is_ws;
    logic                  is_dot;
    logic                  is_digit;
    logic [11:0]           grown;
    logic                  token_ok;
    logic [COUNT_BITS-1:0] count_inc;
    result_t               finish_res;
    result_t               error_res;
    result_t               end_res;

    assign is_ws    = (char_code == CHAR_SPACE)
                   || ((char_code >= CHAR_TAB) && (char_code <= CHAR_CR));
    assign is_dot   = (char_code == CHAR_DOT);
    assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);

    // Times ten as two shifts and an add.
    assign grown = {1'b0, part_value_reg, 3'b000} + {3'b000, part_value_reg, 1'b0}
                 + {4'b0000, char_code - CHAR_ZERO};

    assign token_ok  = (part_index_reg == LAST_PART) && has_digit_reg;
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

    always_comb
    begin
        error_res             = '0;
        error_res.status      = ST_MALFORMED;
        error_res.token_index = INDEX_BITS'(count_reg);
        error_res.last        = 1'b1;

        if (token_ok)
        begin
            finish_res             = '0;
            finish_res.octet_a     = held_a_reg;
            finish_res.octet_b     = held_b_reg;
            finish_res.octet_c     = held_c_reg;
            finish_res.octet_d     = part_value_reg;
            finish_res.status      = ST_PARSED;
            finish_res.token_index = INDEX_BITS'(count_reg);
            finish_res.last        = 1'b1;
        end
        else
        begin
            finish_res = error_res;
        end

        end_res             = '0;
        end_res.status      = ST_END;
        end_res.token_index = INDEX_BITS'(count_reg);
        end_res.last        = 1'b1;
    end

    always_comb
    begin
        in_token_next   = in_token_reg;
        part_index_next = part_index_reg;
        part_value_next = part_value_reg;
        has_digit_next  = has_digit_reg;
        held_a_next     = held_a_reg;
        held_b_next     = held_b_reg;
        held_c_next     = held_c_reg;
        count_next      = count_reg;
        halted_next     = halted_reg;
        push_count      = 2'd0;
        res_first       = end_res;
        res_second      = end_res;

        if (fire)
        begin
            if (end_of_input)
            begin
                // The pending token closes first, then the end word follows.
                if (!halted_reg && in_token_reg)
                begin
                    push_count     = 2'd2;
                    res_first      = finish_res;
                    res_first.last = 1'b0;
                    if (token_ok)
                    begin
                        res_second.token_index = INDEX_BITS'(count_inc);
                    end
                end
                else
                begin
                    push_count = 2'd1;
                end
                in_token_next   = 1'b0;
                part_index_next = '0;
                part_value_next = '0;
                has_digit_next  = 1'b0;
                held_a_next     = '0;
                held_b_next     = '0;
                held_c_next     = '0;
                count_next      = '0;
                halted_next     = 1'b0;
            end
            else if (!halted_reg)
            begin
                priority if (is_ws)
                begin
                    if (in_token_reg)
                    begin
                        push_count      = 2'd1;
                        res_first       = finish_res;
                        in_token_next   = 1'b0;
                        part_index_next = '0;
                        part_value_next = '0;
                        has_digit_next  = 1'b0;
                        held_a_next     = '0;
                        held_b_next     = '0;
                        held_c_next     = '0;
                        if (token_ok)
                        begin
                            count_next = count_inc;
                        end
                        else
                        begin
                            halted_next = 1'b1;
                        end
                    end
                end
                else if (is_dot && has_digit_reg && (part_index_reg != LAST_PART))
                begin
                    in_token_next   = 1'b1;
                    part_index_next = part_index_reg + 1'b1;
                    part_value_next = '0;
                    has_digit_next  = 1'b0;
                    unique case (part_index_reg)
                        2'd0:    held_a_next = part_value_reg;
                        2'd1:    held_b_next = part_value_reg;
                        default: held_c_next = part_value_reg;
                    endcase
                end
                else if (is_digit && (grown <= OCTET_MAX))
                begin
                    in_token_next   = 1'b1;
                    part_value_next = grown[7:0];
                    has_digit_next  = 1'b1;
                end
                else
                begin
                    // Bad byte, bad dot or a part past 255.
                    push_count      = 2'd1;
                    res_first       = error_res;
                    in_token_next   = 1'b0;
                    part_index_next = '0;
                    part_value_next = '0;
                    has_digit_next  = 1'b0;
                    held_a_next     = '0;
                    held_b_next     = '0;
                    held_c_next     = '0;
                    halted_next     = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_token_reg   <= 1'b0;
            part_index_reg <= '0;
            part_value_reg <= '0;
            has_digit_reg  <= 1'b0;
            held_a_reg     <= '0;
            held_b_reg     <= '0;
            held_c_reg     <= '0;
            count_reg      <= '0;
            halted_reg     <= 1'b0;
        end
        else
        begin
            in_token_reg   <= in_token_next;
            part_index_reg <= part_index_next;
            part_value_reg <= part_value_next;
            has_digit_reg  <= has_digit_next;
            held_a_reg     <= held_a_next;
            held_b_reg     <= held_b_next;
            held_c_reg     <= held_c_next;
            count_reg      <= count_next;
            halted_reg     <= halted_next;
        end
    end

endmodule

// File: rtl/dqp_out_fifo.sv
// ----------------------------------------------------------------------------
// dqp_out_fifo
// Four-word result queue that takes up to two words per cycle.
// ----------------------------------------------------------------------------
module dqp_out_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_count,
    input  dqp_pkg::result_t push_first,
    input  dqp_pkg::result_t push_second,
    output logic             has_room,
    output logic             result_valid,
    input  logic             result_stall,
    output dqp_pkg::result_t result_word
);
    import dqp_pkg::*;

    result_t    mem_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] fill_reg, fill_next;
    logic       pop;
    logic [1:0] wr_ptr_plus;

    assign result_valid = (fill_reg != 3'd0);
    assign result_word  = mem_reg[rd_ptr_reg];
    assign pop          = result_valid && !result_stall;
    // Room for the worst case of two words from one byte.
    assign has_room     = (fill_reg <= 3'd2);
    assign wr_ptr_plus  = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_count;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        fill_next   = fill_reg + {1'b0, push_count} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push_first;
        end
        if (push_count == 2'd2)
        begin
            mem_reg[wr_ptr_plus] <= push_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// File: rtl/ipv4_dotted_quad_list_parser.sv
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_list_parser
// Streaming parser for whitespace-separated dotted-quad IPv4 addresses.
// ----------------------------------------------------------------------------
// The block takes one text byte per word and sustains one byte per clock
// cycle. A byte is captured in an input register, and as soon as the output
// queue has room for two words the parse logic updates the token state and
// writes zero, one or two result words into that four-word queue, which
// feeds the result channel in order of arrival. Every token of four
// dot-separated decimal parts (each 0 to 255, leading zeros allowed) gives a
// parsed word with its octets. The first malformed token gives a malformed
// word carrying the number of valid tokens before it, and all later bytes are
// dropped until an end-of-input word, which gives a final count word, marks
// it as last and returns the block to its reset state. End of input in the
// middle of a token gives two words: the token's own word and then the count
// word. The input stalls only while the output queue holds more than two
// words, which happens only when the result side stalls.
// ----------------------------------------------------------------------------
module ipv4_dotted_quad_list_parser (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [7:0] char_code,
    input  logic       end_of_input,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] octet_a,
    output logic [7:0] octet_b,
    output logic [7:0] octet_c,
    output logic [7:0] octet_d,
    output logic [1:0] status,
    output logic [15:0] token_index,
    output logic       last
);
    import dqp_pkg::*;

    logic       held_valid_reg, held_valid_next;
    logic [7:0] held_char_reg;
    logic       held_end_reg;

    logic       has_room;
    logic       fire;
    logic       accept;
    logic [1:0] push_count;
    result_t    res_first;
    result_t    res_second;
    result_t    result_word;

    // The held byte is consumed whenever the queue can take two words; a new
    // byte may enter in the same cycle.
    assign fire       = held_valid_reg && has_room;
    assign item_stall = held_valid_reg && !has_room;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        if (accept)
        begin
            held_valid_next = 1'b1;
        end
        else if (fire)
        begin
            held_valid_next = 1'b0;
        end
        else
        begin
            held_valid_next = held_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
        end
    end

    // Payload of the input register needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_char_reg <= char_code;
            held_end_reg  <= end_of_input;
        end
    end

    dqp_parse_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .char_code    (held_char_reg),
        .end_of_input (held_end_reg),
        .push_count   (push_count),
        .res_first    (res_first),
        .res_second   (res_second)
    );

    dqp_out_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_count   (push_count),
        .push_first   (res_first),
        .push_second  (res_second),
        .has_room     (has_room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

    assign octet_a     = result_word.octet_a;
    assign octet_b     = result_word.octet_b;
    assign octet_c     = result_word.octet_c;
    assign octet_d     = result_word.octet_d;
    assign status      = result_word.status;
    assign token_index = result_word.token_index;
    assign last        = result_word.last;

endmodule
